[hw/rtl/word_substring_subsequence_match_core_macros.svh]
// Assertion macros shared by the matcher RTL.
`ifndef WORD_SUBSTRING_SUBSEQUENCE_MATCH_CORE_MACROS_SVH
`define WORD_SUBSTRING_SUBSEQUENCE_MATCH_CORE_MACROS_SVH

// Implication checked in the same cycle.
`define WSSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define WSSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wssm_pkg.sv]
// Shared constants, types and helpers of the word matcher.
package wssm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int PAT_BYTES   = 16;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 5;
    localparam int PAT_BITS    = PAT_BYTES * CHAR_W;
    localparam int BYTE_IDX_W  = $clog2(PAT_BYTES);
    localparam int WIN_DEPTH   = MAX_PATTERN - 1;
    localparam int CELL_IDX_W  = $clog2(WIN_DEPTH);
    localparam int REG_W       = 64;
    localparam int ADDR_W      = 5;

    // register indexes, decoded from paddr[4:3]
    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_PAT_LO = 2'd1;
    localparam logic [1:0] REG_PAT_HI = 2'd2;

    // one accepted character, broadcast to the cells and the tracker
    typedef struct packed {
        logic accept;
        logic word_end;
    } step_t;

    // tracker status toward the top level
    typedef struct packed {
        logic                 scattered;
        logic [LEN_W-1:0]     pos;
    } track_t;

    function automatic logic [CHAR_W-1:0] pat_byte(input logic [PAT_BITS-1:0] pat,
                                                   input logic [LEN_W-1:0]    idx);
        logic [CHAR_W-1:0] b;
        if (idx >= LEN_W'(PAT_BYTES)) begin
            b = '0;
        end else begin
            b = pat[CHAR_W*idx[BYTE_IDX_W-1:0] +: CHAR_W];
        end
        return b;
    endfunction

endpackage

[hw/rtl/wssm_cell.sv]
// One history cell: holds a past character, shifts it on, and compares it to its pattern byte.
module wssm_cell import wssm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  step_t                 step,
    input  logic [CELL_IDX_W-1:0] cell_idx,
    input  logic [LEN_W-1:0]      pat_len,
    input  logic [PAT_BITS-1:0]   pattern,
    input  logic [CHAR_W-1:0]     char_in,
    input  logic                  inword_in,
    output logic [CHAR_W-1:0]     char_out,
    output logic                  inword_out,
    output logic                  match
);

    logic [CHAR_W-1:0] hist_reg;
    logic              inword_reg;
    logic [LEN_W:0]    tail;
    logic [LEN_W-1:0]  sel_idx;

    // this cell sits tail characters behind the current one
    assign tail    = (LEN_W+1)'(cell_idx) + (LEN_W+1)'(1);
    assign sel_idx = pat_len - tail[LEN_W-1:0] - LEN_W'(1);

    assign match = (tail >= {1'b0, pat_len})
                 || (inword_reg && (hist_reg == pat_byte(pattern, sel_idx)));

    always_ff @(posedge aclk) begin
        if (step.accept) begin
            hist_reg <= char_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inword_reg <= 1'b0;
        end else if (step.accept) begin
            inword_reg <= step.word_end ? 1'b0 : inword_in;
        end
    end

    assign char_out   = hist_reg;
    assign inword_out = inword_reg;

endmodule

[hw/rtl/wssm_subseq.sv]
// Greedy leftmost subsequence tracker with adjacency bookkeeping.
module wssm_subseq import wssm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  step_t               step,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [LEN_W-1:0]    pat_len,
    input  logic [PAT_BITS-1:0] pattern,
    output track_t              status
);

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic             adj_reg, adj_next;
    logic             contig_reg, contig_next;

    always_comb begin
        pos_next    = pos_reg;
        adj_next    = adj_reg;
        contig_next = contig_reg;
        if (pos_reg < pat_len) begin
            if (char_code == pat_byte(pattern, pos_reg)) begin
                if (pos_reg == '0) begin
                    contig_next = 1'b1;
                    adj_next    = 1'b1;
                end
                if (!adj_next) begin
                    contig_next = 1'b0;
                end
                pos_next = pos_reg + LEN_W'(1);
            end else begin
                adj_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            adj_reg    <= 1'b0;
            contig_reg <= 1'b0;
        end else if (step.accept) begin
            if (step.word_end) begin
                pos_reg    <= '0;
                adj_reg    <= 1'b0;
                contig_reg <= 1'b0;
            end else begin
                pos_reg    <= pos_next;
                adj_reg    <= adj_next;
                contig_reg <= contig_next;
            end
        end
    end

    assign status.scattered = (pat_len > LEN_W'(1)) && (pos_next == pat_len) && !contig_next;
    assign status.pos       = pos_reg;

endmodule

[hw/rtl/word_substring_subsequence_match_core.sv]
// Top level of the word substring / scattered-subsequence matcher.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_char_code, s_word_end
//  m_        out        m_valid / m_ready    m_substring_hit, m_scattered_hit
//  apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// One character per cycle: a row of 15 history cells compares the window in parallel
// and the tracker does one update per character. A word-end request loads the output
// register; the result appears the cycle after. s_ready drops only while a result waits
// and m_ready is low. Synchronous active-low reset clears control and config state only.
`include "word_substring_subsequence_match_core_macros.svh"
module word_substring_subsequence_match_core import wssm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CHAR_W-1:0]  s_char_code,
    input  logic               s_word_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_substring_hit,
    output logic               m_scattered_hit,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [REG_W-1:0]   pwdata,
    output logic [REG_W-1:0]   prdata,
    output logic               pready
);

    logic [LEN_W-1:0]     len_cfg_reg;
    logic [PAT_BITS-1:0]  pattern_reg;
    logic [LEN_W-1:0]     len_eff;
    logic                 cfg_wr;

    step_t                step;
    track_t               trk;
    logic [CHAR_W-1:0]    char_chain [0:WIN_DEPTH-1];
    logic                 inword_chain [0:WIN_DEPTH-1];
    logic [WIN_DEPTH-1:0] cell_match;

    logic                 seen_reg, seen_next, hit_now;
    logic                 m_valid_reg, sub_reg, scat_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg <= '0;
            pattern_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_LENGTH: len_cfg_reg <= pwdata[LEN_W-1:0];
                REG_PAT_LO: pattern_reg[REG_W-1:0] <= pwdata;
                REG_PAT_HI: pattern_reg[PAT_BITS-1:REG_W] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_LENGTH: prdata = REG_W'(len_cfg_reg);
            REG_PAT_LO: prdata = pattern_reg[REG_W-1:0];
            REG_PAT_HI: prdata = pattern_reg[PAT_BITS-1:REG_W];
            default:    prdata = '0;
        endcase
    end

    assign len_eff = (len_cfg_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_cfg_reg;

    // input side
    assign s_ready       = !m_valid_reg || m_ready;
    assign step.accept   = s_valid && s_ready;
    assign step.word_end = s_word_end;

    // history row: cell 0 takes the current character
    for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
        logic [CHAR_W-1:0] c_in;
        logic              w_in;
        if (i == 0) begin : g_head
            assign c_in = s_char_code;
            assign w_in = 1'b1;
        end else begin : g_body
            assign c_in = char_chain[i-1];
            assign w_in = inword_chain[i-1];
        end
        wssm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .step       (step),
            .cell_idx   (CELL_IDX_W'(i)),
            .pat_len    (len_eff),
            .pattern    (pattern_reg),
            .char_in    (c_in),
            .inword_in  (w_in),
            .char_out   (char_chain[i]),
            .inword_out (inword_chain[i]),
            .match      (cell_match[i])
        );
    end

    wssm_subseq u_subseq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .char_code (s_char_code),
        .pat_len   (len_eff),
        .pattern   (pattern_reg),
        .status    (trk)
    );

    // empty pattern or earlier hit in the word matches; else newest byte plus the whole row
    assign hit_now = seen_reg || (len_eff == '0)
                  || ((s_char_code == pat_byte(pattern_reg, len_eff - LEN_W'(1))) && (&cell_match));
    assign seen_next = s_word_end ? 1'b0 : hit_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (step.accept) begin
            seen_reg <= seen_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step.accept && s_word_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.accept && s_word_end) begin
            sub_reg  <= hit_now;
            scat_reg <= trk.scattered;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_substring_hit = sub_reg;
    assign m_scattered_hit = scat_reg;

    `WSSM_ASSERT_NEXT(a_end_gives_result, step.accept && s_word_end, m_valid, "word end lost")
    `WSSM_ASSERT_NEXT(a_no_spurious, step.accept && !s_word_end && m_ready, !m_valid, "spurious result")
    `WSSM_ASSERT_SAME(a_pos_bound, 1'b1, trk.pos <= LEN_W'(MAX_PATTERN), "tracker overran pattern")

endmodule
